/* src/ptm_pkg.sv */
// Shared types, constants and descriptor helpers for the page table mapper.
`timescale 1ns / 1ps

package ptm_pkg;

    // Fixed geometry of the 4KB granule and of the request/result fields
    localparam int TABLE_ENTRIES = 512;
    localparam int IDX_W         = 9;
    localparam int VA_W          = 27;
    localparam int PAGE_W        = 36;
    localparam int ATTR_W        = 3;
    localparam int LEVEL_W       = 2;
    localparam int SLOT_W        = 6;
    localparam int DESC_W        = 64;
    localparam int CFG_IDX_W     = 1;

    // Default pool sizes
    localparam int L2_TABLES_DEF = 16;
    localparam int L3_TABLES_DEF = 64;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_L2_POOL_BASE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_L3_POOL_BASE = 1'd1;

    // Table level codes
    localparam logic [LEVEL_W-1:0] LVL_L1 = 2'd0;
    localparam logic [LEVEL_W-1:0] LVL_L2 = 2'd1;
    localparam logic [LEVEL_W-1:0] LVL_L3 = 2'd2;

    // Descriptor bit constants
    localparam logic [1:0]        DESC_VALID_TYPE = 2'b11;
    localparam logic [1:0]        DESC_SH_INNER   = 2'b11;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ_L1,
        ST_DECIDE,
        ST_EMIT_L2,
        ST_EMIT_L3
    } ptm_state_t;

    // Read/write strobes toward the child maps
    typedef struct packed {
        logic l1_rd;
        logic l1_wr;
        logic l2_rd;
        logic l2_wr;
    } map_ctrl_t;

    // One descriptor write result
    typedef struct packed {
        logic [LEVEL_W-1:0] level;
        logic [SLOT_W-1:0]  slot;
        logic [IDX_W-1:0]   entry;
        logic [DESC_W-1:0]  desc;
        logic               fresh;
        logic               err;
        logic               last;
    } result_t;

    // Table descriptor: next-level table page, valid + table type
    function automatic logic [DESC_W-1:0] table_desc(input logic [PAGE_W-1:0] page);
        table_desc = {16'h0000, page, 10'h000, DESC_VALID_TYPE};
    endfunction

    // Level-3 page descriptor: AF, inner shareable, AP[2], AttrIndx, XN pair
    function automatic logic [DESC_W-1:0] page_desc(
        input logic [PAGE_W-1:0] pa,
        input logic [ATTR_W-1:0] attr,
        input logic              ro,
        input logic              ex
    );
        page_desc = {9'h000, ~ex, ~ex, 5'h00, pa, 1'b0, 1'b1, DESC_SH_INNER, ro,
                     2'b00, attr, DESC_VALID_TYPE};
    endfunction

endpackage

/* src/ptm_maps.sv */
// Child map memories for level-1 and level-2 entries, with post-reset clearing sweep.
`timescale 1ns / 1ps

module ptm_maps #(
    parameter int L2_TABLES = ptm_pkg::L2_TABLES_DEF,
    parameter int L3_TABLES = ptm_pkg::L3_TABLES_DEF,
    localparam int L2W      = (L2_TABLES > 1) ? $clog2(L2_TABLES) : 1,
    localparam int L3W      = (L3_TABLES > 1) ? $clog2(L3_TABLES) : 1,
    localparam int L2_DEPTH = L2_TABLES * ptm_pkg::TABLE_ENTRIES,
    localparam int L2A      = $clog2(L2_DEPTH)
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  ptm_pkg::map_ctrl_t         mctl,
    input  logic [ptm_pkg::IDX_W-1:0]  l1_rd_addr,
    input  logic [ptm_pkg::IDX_W-1:0]  l1_wr_addr,
    input  logic [L2W:0]               l1_wr_data,
    input  logic [L2A-1:0]             l2_rd_addr,
    input  logic [L2A-1:0]             l2_wr_addr,
    input  logic [L3W:0]               l2_wr_data,
    output logic [L2W:0]               l1_rd_data,
    output logic [L3W:0]               l2_rd_data,
    output logic                       clear_busy
);

    // entry = {valid, slot}
    logic [L2W:0] l1_mem [0:ptm_pkg::TABLE_ENTRIES-1];
    logic [L3W:0] l2_mem [0:L2_DEPTH-1];

    logic [L2A-1:0] clr_cnt_reg, clr_cnt_next;
    logic           clr_busy_reg, clr_busy_next;
    logic [L2W:0]   l1_rd_reg;
    logic [L3W:0]   l2_rd_reg;

    always_comb
    begin
        clr_cnt_next  = clr_cnt_reg;
        clr_busy_next = clr_busy_reg;
        if (clr_busy_reg)
        begin
            clr_cnt_next = clr_cnt_reg + L2A'(1);
            if (clr_cnt_reg == L2A'(L2_DEPTH - 1))
            begin
                clr_busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg  <= '0;
            clr_busy_reg <= 1'b1;
        end
        else
        begin
            clr_cnt_reg  <= clr_cnt_next;
            clr_busy_reg <= clr_busy_next;
        end
    end

    // Level-1 map: sweep rewrites the low 512 addresses, harmless repeats
    always_ff @(posedge clk)
    begin
        if (clr_busy_reg)
        begin
            l1_mem[clr_cnt_reg[ptm_pkg::IDX_W-1:0]] <= '0;
        end
        else if (mctl.l1_wr)
        begin
            l1_mem[l1_wr_addr] <= l1_wr_data;
        end
        if (mctl.l1_rd)
        begin
            l1_rd_reg <= l1_mem[l1_rd_addr];
        end
    end

    // Level-2 map
    always_ff @(posedge clk)
    begin
        if (clr_busy_reg)
        begin
            l2_mem[clr_cnt_reg] <= '0;
        end
        else if (mctl.l2_wr)
        begin
            l2_mem[l2_wr_addr] <= l2_wr_data;
        end
        if (mctl.l2_rd)
        begin
            l2_rd_reg <= l2_mem[l2_rd_addr];
        end
    end

    assign l1_rd_data = l1_rd_reg;
    assign l2_rd_data = l2_rd_reg;
    assign clear_busy = clr_busy_reg;

endmodule

/* src/ptm_ctrl.sv */
// Request sequencer: map lookups, pool allocation and descriptor result register.
`timescale 1ns / 1ps

module ptm_ctrl #(
    parameter int L2_TABLES = ptm_pkg::L2_TABLES_DEF,
    parameter int L3_TABLES = ptm_pkg::L3_TABLES_DEF,
    localparam int L2W      = (L2_TABLES > 1) ? $clog2(L2_TABLES) : 1,
    localparam int L3W      = (L3_TABLES > 1) ? $clog2(L3_TABLES) : 1,
    localparam int L2C      = $clog2(L2_TABLES + 1),
    localparam int L3C      = $clog2(L3_TABLES + 1),
    localparam int L2A      = $clog2(L2_TABLES * ptm_pkg::TABLE_ENTRIES)
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic [ptm_pkg::PAGE_W-1:0]  l2_base,
    input  logic [ptm_pkg::PAGE_W-1:0]  l3_base,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic [ptm_pkg::VA_W-1:0]    va_page,
    input  logic [ptm_pkg::PAGE_W-1:0]  pa_page,
    input  logic [ptm_pkg::ATTR_W-1:0]  attr_index,
    input  logic                        read_only,
    input  logic                        executable,
    output logic                        out_valid,
    input  logic                        out_stall,
    output ptm_pkg::result_t            result,
    output ptm_pkg::map_ctrl_t          mctl,
    output logic [ptm_pkg::IDX_W-1:0]   l1_rd_addr,
    output logic [ptm_pkg::IDX_W-1:0]   l1_wr_addr,
    output logic [L2W:0]                l1_wr_data,
    output logic [L2A-1:0]              l2_rd_addr,
    output logic [L2A-1:0]              l2_wr_addr,
    output logic [L3W:0]                l2_wr_data,
    input  logic [L2W:0]                l1_rd_data,
    input  logic [L3W:0]                l2_rd_data,
    input  logic                        clear_busy
);

    localparam int IW = ptm_pkg::IDX_W;
    localparam int SW = (L2W > L3W) ? ((L2W > ptm_pkg::SLOT_W) ? L2W : ptm_pkg::SLOT_W)
                                    : ((L3W > ptm_pkg::SLOT_W) ? L3W : ptm_pkg::SLOT_W);

    ptm_pkg::ptm_state_t state_reg, state_next;

    // captured request
    logic [ptm_pkg::VA_W-1:0]   va_reg;
    logic [ptm_pkg::PAGE_W-1:0] pa_reg;
    logic [ptm_pkg::ATTR_W-1:0] attr_reg;
    logic                       ro_reg;
    logic                       ex_reg;

    // decision held for the later results
    logic           new_l2_reg, new_l3_reg;
    logic [L2W-1:0] s2_reg;
    logic [L3W-1:0] s3_reg;

    logic [L2C-1:0] l2_used_reg, l2_used_next;
    logic [L3C-1:0] l3_used_reg, l3_used_next;

    logic             out_valid_reg;
    ptm_pkg::result_t out_data_reg;

    logic accept, out_free, fire, load;
    logic dec_new_l2, dec_new_l3, dec_err;
    logic [L2W-1:0] dec_s2, sel_s2;
    logic [L3W-1:0] dec_s3, sel_s3;
    logic           sel_new_l2, sel_new_l3;
    logic [SW-1:0]  s2_wide, s3_wide;
    logic [L2W+IW-1:0] l2_rd_full, l2_wr_full;
    ptm_pkg::result_t res, res_l1, res_l2, res_l3, res_err;

    assign accept   = in_valid && !in_stall;
    assign out_free = !out_valid_reg || !out_stall;
    assign fire     = (state_reg == ptm_pkg::ST_DECIDE) && out_free;

    // Lookup results, valid in DECIDE
    assign dec_new_l2 = !l1_rd_data[L2W];
    assign dec_new_l3 = dec_new_l2 || !l2_rd_data[L3W];
    assign dec_s2     = dec_new_l2 ? L2W'(l2_used_reg) : l1_rd_data[L2W-1:0];
    assign dec_s3     = dec_new_l3 ? L3W'(l3_used_reg) : l2_rd_data[L3W-1:0];
    assign dec_err    = (dec_new_l2 && (l2_used_reg == L2C'(L2_TABLES)))
                     || (dec_new_l3 && (l3_used_reg == L3C'(L3_TABLES)));

    assign sel_s2     = (state_reg == ptm_pkg::ST_DECIDE) ? dec_s2 : s2_reg;
    assign sel_s3     = (state_reg == ptm_pkg::ST_DECIDE) ? dec_s3 : s3_reg;
    assign sel_new_l2 = (state_reg == ptm_pkg::ST_DECIDE) ? dec_new_l2 : new_l2_reg;
    assign sel_new_l3 = (state_reg == ptm_pkg::ST_DECIDE) ? dec_new_l3 : new_l3_reg;
    assign s2_wide    = SW'(sel_s2);
    assign s3_wide    = SW'(sel_s3);

    // Candidate results
    always_comb begin
        res_l1       = '0;
        res_l1.level = ptm_pkg::LVL_L1;
        res_l1.entry = va_reg[3*IW-1:2*IW];
        res_l1.desc  = ptm_pkg::table_desc(l2_base + ptm_pkg::PAGE_W'({sel_s2, 1'b0}));

        res_l2       = '0;
        res_l2.level = ptm_pkg::LVL_L2;
        res_l2.slot  = s2_wide[ptm_pkg::SLOT_W-1:0];
        res_l2.entry = va_reg[2*IW-1:IW];
        res_l2.desc  = ptm_pkg::table_desc(l3_base + ptm_pkg::PAGE_W'(sel_s3));
        res_l2.fresh = sel_new_l2;

        res_l3       = '0;
        res_l3.level = ptm_pkg::LVL_L3;
        res_l3.slot  = s3_wide[ptm_pkg::SLOT_W-1:0];
        res_l3.entry = va_reg[IW-1:0];
        res_l3.desc  = ptm_pkg::page_desc(pa_reg, attr_reg, ro_reg, ex_reg);
        res_l3.fresh = sel_new_l3;
        res_l3.last  = 1'b1;

        res_err      = '0;
        res_err.err  = 1'b1;
        res_err.last = 1'b1;
    end

    assign l2_rd_full = {l1_rd_data[L2W-1:0], va_reg[2*IW-1:IW]};
    assign l2_wr_full = {dec_s2, va_reg[2*IW-1:IW]};

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ptm_pkg::ST_IDLE: begin
                if (accept) begin
                    state_next = ptm_pkg::ST_READ_L1;
                end
            end
            ptm_pkg::ST_READ_L1: begin
                state_next = ptm_pkg::ST_DECIDE;
            end
            ptm_pkg::ST_DECIDE: begin
                if (out_free) begin
                    priority if (dec_err) begin
                        state_next = ptm_pkg::ST_IDLE;
                    end else if (dec_new_l2) begin
                        state_next = ptm_pkg::ST_EMIT_L2;
                    end else if (dec_new_l3) begin
                        state_next = ptm_pkg::ST_EMIT_L3;
                    end else begin
                        state_next = ptm_pkg::ST_IDLE;
                    end
                end
            end
            ptm_pkg::ST_EMIT_L2: begin
                if (out_free) begin
                    state_next = ptm_pkg::ST_EMIT_L3;
                end
            end
            ptm_pkg::ST_EMIT_L3: begin
                if (out_free) begin
                    state_next = ptm_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = ptm_pkg::ST_IDLE;
            end
        endcase
    end

    // Outputs: map strobes, result selection
    always_comb begin
        mctl       = '0;
        load       = 1'b0;
        res        = res_l3;
        in_stall   = (state_reg != ptm_pkg::ST_IDLE) || clear_busy;
        l1_rd_addr = va_page[3*IW-1:2*IW];
        l1_wr_addr = va_reg[3*IW-1:2*IW];
        l1_wr_data = {1'b1, dec_s2};
        l2_rd_addr = l2_rd_full[L2A-1:0];
        l2_wr_addr = l2_wr_full[L2A-1:0];
        l2_wr_data = {1'b1, dec_s3};
        unique case (state_reg)
            ptm_pkg::ST_IDLE: begin
                mctl.l1_rd = accept;
            end
            ptm_pkg::ST_READ_L1: begin
                mctl.l2_rd = 1'b1;
            end
            ptm_pkg::ST_DECIDE: begin
                load = out_free;
                priority if (dec_err) begin
                    res = res_err;
                end else if (dec_new_l2) begin
                    res = res_l1;
                end else if (dec_new_l3) begin
                    res = res_l2;
                end else begin
                    res = res_l3;
                end
                mctl.l1_wr = fire && !dec_err && dec_new_l2;
                mctl.l2_wr = fire && !dec_err && dec_new_l3;
            end
            ptm_pkg::ST_EMIT_L2: begin
                load = out_free;
                res  = res_l2;
            end
            ptm_pkg::ST_EMIT_L3: begin
                load = out_free;
                res  = res_l3;
            end
            default: begin
                load = 1'b0;
            end
        endcase
    end

    always_comb begin
        l2_used_next = l2_used_reg;
        l3_used_next = l3_used_reg;
        if (fire && !dec_err) begin
            l2_used_next = l2_used_reg + L2C'(dec_new_l2);
            l3_used_next = l3_used_reg + L3C'(dec_new_l3);
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            state_reg     <= ptm_pkg::ST_IDLE;
            l2_used_reg   <= '0;
            l3_used_reg   <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            l2_used_reg <= l2_used_next;
            l3_used_reg <= l3_used_next;
            if (load) begin
                out_valid_reg <= 1'b1;
            end else if (!out_stall) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge clk) begin
        if (accept) begin
            va_reg   <= va_page;
            pa_reg   <= pa_page;
            attr_reg <= attr_index;
            ro_reg   <= read_only;
            ex_reg   <= executable;
        end
        if (fire) begin
            new_l2_reg <= dec_new_l2;
            new_l3_reg <= dec_new_l3;
            s2_reg     <= dec_s2;
            s3_reg     <= dec_s3;
        end
        if (load) begin
            out_data_reg <= res;
        end
    end

    assign out_valid = out_valid_reg;
    assign result    = out_data_reg;

    a_accept_starts_lookup: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg == ptm_pkg::ST_READ_L1))
        else $error("accepted request did not start the map lookup");

    a_no_write_while_clearing: assert property (@(posedge clk) disable iff (!rst_n)
        clear_busy |-> !(mctl.l1_wr || mctl.l2_wr))
        else $error("map write during clearing sweep");

    a_error_keeps_pools: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && dec_err) |=> ($stable(l2_used_reg) && $stable(l3_used_reg)))
        else $error("pool counter moved on an exhausted-pool request");

    a_pools_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        (l2_used_reg <= L2C'(L2_TABLES)) && (l3_used_reg <= L3C'(L3_TABLES)))
        else $error("pool counter beyond pool size");

    a_last_ends_request: assert property (@(posedge clk) disable iff (!rst_n)
        (load && res.last) |=> (state_reg == ptm_pkg::ST_IDLE))
        else $error("final result loaded but sequencer not idle");

endmodule

/* src/page_table_mapper.sv */
// Top level of the page table mapper: configuration registers, sequencer and child maps.
`timescale 1ns / 1ps

// Builds a stage-1 4KB-granule translation table one page at a time. Each
// request (va_page, pa_page, attr_index, read_only, executable) yields, in
// order: an L1 table descriptor if a new L2 table was taken, an L2 table
// descriptor if a new L3 table was taken, then the L3 page descriptor; last
// marks the final result. table_fresh tells the receiver to clear the table
// before writing. If a needed pool is exhausted, one result with pool_error
// set comes out and nothing changes. L2 tables are taken from
// l2_pool_base_page in steps of two pages, L3 tables from l3_pool_base_page
// in steps of one page, both in bump order. The level-1 and level-2 child
// maps live in two memories, each with a single registered read port. A
// request passes through the L1 map read, the L2 map read and the decision
// state before its first result is loaded into the output register.
// Further results come from EMIT_L2 and EMIT_L3; out_stall holds any
// result. The final result may wait in the output register while the next
// request is accepted. After reset the maps are swept clear, one entry a
// cycle, over L2_TABLES * 512 entries (8192 at defaults); in_stall stays
// high during the sweep while configuration writes are taken as usual. Pool
// base registers should be written only when no request is in flight.
module page_table_mapper #(
    parameter int L2_TABLES = ptm_pkg::L2_TABLES_DEF,
    parameter int L3_TABLES = ptm_pkg::L3_TABLES_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    // request channel
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic [ptm_pkg::VA_W-1:0]       va_page,
    input  logic [ptm_pkg::PAGE_W-1:0]     pa_page,
    input  logic [ptm_pkg::ATTR_W-1:0]     attr_index,
    input  logic                           read_only,
    input  logic                           executable,
    // result channel
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic [ptm_pkg::LEVEL_W-1:0]    table_level,
    output logic [ptm_pkg::SLOT_W-1:0]     table_slot,
    output logic [ptm_pkg::IDX_W-1:0]      entry_index,
    output logic [ptm_pkg::DESC_W-1:0]     descriptor,
    output logic                           table_fresh,
    output logic                           pool_error,
    output logic                           last,
    // configuration write channel
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [ptm_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [ptm_pkg::PAGE_W-1:0]     cfg_data
);

    localparam int L2W = (L2_TABLES > 1) ? $clog2(L2_TABLES) : 1;
    localparam int L3W = (L3_TABLES > 1) ? $clog2(L3_TABLES) : 1;
    localparam int L2A = $clog2(L2_TABLES * ptm_pkg::TABLE_ENTRIES);

    logic [ptm_pkg::PAGE_W-1:0] l2_base_reg, l2_base_next;
    logic [ptm_pkg::PAGE_W-1:0] l3_base_reg, l3_base_next;

    ptm_pkg::map_ctrl_t        mctl;
    ptm_pkg::result_t          result;
    logic [ptm_pkg::IDX_W-1:0] l1_rd_addr, l1_wr_addr;
    logic [L2W:0]              l1_wr_data, l1_rd_data;
    logic [L2A-1:0]            l2_rd_addr, l2_wr_addr;
    logic [L3W:0]              l2_wr_data, l2_rd_data;
    logic                      clear_busy;

    // Pool base registers; always ready
    assign cfg_ready = 1'b1;

    always_comb begin
        l2_base_next = l2_base_reg;
        l3_base_next = l3_base_reg;
        if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                ptm_pkg::REG_L2_POOL_BASE: l2_base_next = cfg_data;
                ptm_pkg::REG_L3_POOL_BASE: l3_base_next = cfg_data;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            l2_base_reg <= '0;
            l3_base_reg <= '0;
        end else begin
            l2_base_reg <= l2_base_next;
            l3_base_reg <= l3_base_next;
        end
    end

    ptm_ctrl #(
        .L2_TABLES (L2_TABLES),
        .L3_TABLES (L3_TABLES)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .l2_base    (l2_base_reg),
        .l3_base    (l3_base_reg),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .va_page    (va_page),
        .pa_page    (pa_page),
        .attr_index (attr_index),
        .read_only  (read_only),
        .executable (executable),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .result     (result),
        .mctl       (mctl),
        .l1_rd_addr (l1_rd_addr),
        .l1_wr_addr (l1_wr_addr),
        .l1_wr_data (l1_wr_data),
        .l2_rd_addr (l2_rd_addr),
        .l2_wr_addr (l2_wr_addr),
        .l2_wr_data (l2_wr_data),
        .l1_rd_data (l1_rd_data),
        .l2_rd_data (l2_rd_data),
        .clear_busy (clear_busy)
    );

    ptm_maps #(
        .L2_TABLES (L2_TABLES),
        .L3_TABLES (L3_TABLES)
    ) u_maps (
        .clk        (clk),
        .rst_n      (rst_n),
        .mctl       (mctl),
        .l1_rd_addr (l1_rd_addr),
        .l1_wr_addr (l1_wr_addr),
        .l1_wr_data (l1_wr_data),
        .l2_rd_addr (l2_rd_addr),
        .l2_wr_addr (l2_wr_addr),
        .l2_wr_data (l2_wr_data),
        .l1_rd_data (l1_rd_data),
        .l2_rd_data (l2_rd_data),
        .clear_busy (clear_busy)
    );

    // Result register fields onto the ports
    assign table_level = result.level;
    assign table_slot  = result.slot;
    assign entry_index = result.entry;
    assign descriptor  = result.desc;
    assign table_fresh = result.fresh;
    assign pool_error  = result.err;
    assign last        = result.last;

endmodule

/* test/ptm_checker.sv */
`timescale 1ns / 1ps
// Scoreboard for the page table mapper: tracks table allocation and checks each result.

module ptm_checker #(
    parameter int L2_TABLES = ptm_pkg::L2_TABLES_DEF,
    parameter int L3_TABLES = ptm_pkg::L3_TABLES_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    input  logic                          in_stall,
    input  logic [ptm_pkg::VA_W-1:0]      va_page,
    input  logic [ptm_pkg::PAGE_W-1:0]    pa_page,
    input  logic [ptm_pkg::ATTR_W-1:0]    attr_index,
    input  logic                          read_only,
    input  logic                          executable,
    input  logic                          out_valid,
    input  logic                          out_stall,
    input  logic [ptm_pkg::LEVEL_W-1:0]   table_level,
    input  logic [ptm_pkg::SLOT_W-1:0]    table_slot,
    input  logic [ptm_pkg::IDX_W-1:0]     entry_index,
    input  logic [ptm_pkg::DESC_W-1:0]    descriptor,
    input  logic                          table_fresh,
    input  logic                          pool_error,
    input  logic                          last,
    input  logic                          cfg_valid,
    input  logic                          cfg_ready,
    input  logic [ptm_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [ptm_pkg::PAGE_W-1:0]    cfg_data,
    output int                            mismatches,
    output int                            writes_pending
);

    localparam logic [ptm_pkg::DESC_W-1:0] D_TYPE = 64'h3;
    localparam logic [ptm_pkg::DESC_W-1:0] D_SH   = 64'h300;
    localparam logic [ptm_pkg::DESC_W-1:0] D_AF   = 64'h400;
    localparam logic [ptm_pkg::DESC_W-1:0] D_XN   = (64'h1 << 53) | (64'h1 << 54);

    logic [ptm_pkg::PAGE_W-1:0] l2_base;
    logic [ptm_pkg::PAGE_W-1:0] l3_base;
    bit                l1_taken [ptm_pkg::TABLE_ENTRIES];
    int                l1_slot  [ptm_pkg::TABLE_ENTRIES];
    bit                l2_taken [L2_TABLES*ptm_pkg::TABLE_ENTRIES];
    int                l2_slot  [L2_TABLES*ptm_pkg::TABLE_ENTRIES];
    int                l2_used;
    int                l3_used;
    ptm_pkg::result_t  desc_writes [$];

    function automatic logic [ptm_pkg::DESC_W-1:0] table_word(
        input logic [ptm_pkg::PAGE_W-1:0] page);
        return (ptm_pkg::DESC_W'(page) << 12) | D_TYPE;
    endfunction

    function automatic void queue_write(input logic [ptm_pkg::LEVEL_W-1:0] level,
                                        input int slot, input int entry,
                                        input logic [ptm_pkg::DESC_W-1:0] desc,
                                        input bit fresh, input bit err, input bit fin);
        ptm_pkg::result_t w;
        w.level = level;
        w.slot  = ptm_pkg::SLOT_W'(slot);
        w.entry = ptm_pkg::IDX_W'(entry);
        w.desc  = desc;
        w.fresh = fresh;
        w.err   = err;
        w.last  = fin;
        desc_writes.push_back(w);
    endfunction

    // Works out the descriptor writes of one mapping request and takes tables.
    task automatic map_request(input logic [ptm_pkg::VA_W-1:0] va,
                               input logic [ptm_pkg::PAGE_W-1:0] pa,
                               input logic [ptm_pkg::ATTR_W-1:0] attr, input logic ro,
                               input logic ex);
        int                         i1;
        int                         i2;
        int                         i3;
        int                         s2;
        int                         s3;
        int                         m2;
        bit                         need_l2;
        bit                         need_l3;
        logic [ptm_pkg::DESC_W-1:0] leaf;
        i1 = va[26:18];
        i2 = va[17:9];
        i3 = va[8:0];
        need_l2 = !l1_taken[i1];
        s2 = need_l2 ? l2_used : l1_slot[i1];
        m2 = s2 * ptm_pkg::TABLE_ENTRIES + i2;
        need_l3 = 1'b1;
        if (!need_l2)
            need_l3 = !l2_taken[m2];
        // pool exhausted: a lone error result, nothing taken
        if ((need_l2 && l2_used >= L2_TABLES) || (need_l3 && l3_used >= L3_TABLES))
        begin
            queue_write(ptm_pkg::LVL_L1, 0, 0, '0, 1'b0, 1'b1, 1'b1);
            return;
        end
        if (need_l2)
        begin
            l1_taken[i1] = 1'b1;
            l1_slot[i1]  = s2;
            l2_used++;
            queue_write(ptm_pkg::LVL_L1, 0, i1,
                        table_word(l2_base + ptm_pkg::PAGE_W'(2 * s2)),
                        1'b0, 1'b0, 1'b0);
        end
        if (need_l3)
        begin
            s3 = l3_used;
            l3_used++;
            l2_taken[m2] = 1'b1;
            l2_slot[m2]  = s3;
            queue_write(ptm_pkg::LVL_L2, s2, i2,
                        table_word(l3_base + ptm_pkg::PAGE_W'(s3)),
                        need_l2, 1'b0, 1'b0);
        end
        else
            s3 = l2_slot[m2];
        leaf = (ptm_pkg::DESC_W'(pa) << 12) | D_TYPE | D_SH | D_AF
             | (ptm_pkg::DESC_W'(attr) << 2) | (ptm_pkg::DESC_W'(ro) << 7);
        if (!ex)
            leaf = leaf | D_XN;
        queue_write(ptm_pkg::LVL_L3, s3, i3, leaf, need_l3, 1'b0, 1'b1);
    endtask

    task automatic flag(input string msg);
        $display("%0t ptm_checker: %s", $time, msg);
        mismatches++;
    endtask

    task automatic check_field(input string name, input logic [63:0] got,
                               input logic [63:0] want);
        if (got !== want)
            flag($sformatf("%s got 0x%0h want 0x%0h", name, got, want));
    endtask

    always @(posedge clk)
    begin
        ptm_pkg::result_t want;
        if (!rst_n)
        begin
            l2_base = '0;
            l3_base = '0;
            foreach (l1_taken[i])
                l1_taken[i] = 1'b0;
            foreach (l2_taken[i])
                l2_taken[i] = 1'b0;
            l2_used = 0;
            l3_used = 0;
            mismatches = 0;
            desc_writes.delete();
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == ptm_pkg::REG_L2_POOL_BASE)
                    l2_base = cfg_data;
                else if (cfg_index == ptm_pkg::REG_L3_POOL_BASE)
                    l3_base = cfg_data;
            end
            if (in_valid && !in_stall)
                map_request(va_page, pa_page, attr_index, read_only, executable);
            if (out_valid && !out_stall)
            begin
                if (desc_writes.size() == 0)
                    flag($sformatf("result with nothing pending, level %0d entry %0d",
                                   table_level, entry_index));
                else
                begin
                    want = desc_writes.pop_front();
                    check_field("table_level", table_level, want.level);
                    check_field("table_slot", table_slot, want.slot);
                    check_field("entry_index", entry_index, want.entry);
                    check_field("descriptor", descriptor, want.desc);
                    check_field("table_fresh", table_fresh, want.fresh);
                    check_field("pool_error", pool_error, want.err);
                    check_field("last", last, want.last);
                end
            end
        end
        writes_pending = desc_writes.size();
    end

endmodule

/* test/tb_page_table_mapper.sv */
`timescale 1ns / 1ps
// Testbench top for the page table mapper: clock, reset, stimulus and verdict.

module tb_page_table_mapper;

    // The limit covers the reset sweep and the rest of the run, even with
    // every stall at its longest.
    localparam int CYCLE_LIMIT = 300000;
    localparam int HOLD_AFTER  = 60;   // requests sent before the long hold
    localparam int HOLD_CYCLES = 400;

    logic                          clk = 1'b0;
    logic                          rst_n = 1'b0;
    logic                          in_valid = 1'b0;
    logic                          in_stall;
    logic [ptm_pkg::VA_W-1:0]      va_page = '0;
    logic [ptm_pkg::PAGE_W-1:0]    pa_page = '0;
    logic [ptm_pkg::ATTR_W-1:0]    attr_index = '0;
    logic                          read_only = 1'b0;
    logic                          executable = 1'b0;
    logic                          out_valid;
    logic                          out_stall = 1'b0;
    logic [ptm_pkg::LEVEL_W-1:0]   table_level;
    logic [ptm_pkg::SLOT_W-1:0]    table_slot;
    logic [ptm_pkg::IDX_W-1:0]     entry_index;
    logic [ptm_pkg::DESC_W-1:0]    descriptor;
    logic                          table_fresh;
    logic                          pool_error;
    logic                          last;
    logic                          cfg_valid = 1'b0;
    logic                          cfg_ready;
    logic [ptm_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    logic [ptm_pkg::PAGE_W-1:0]    cfg_data = '0;
    int                            mismatches;
    int                            writes_pending;

    int                            cycles = 0;
    int                            requests_sent = 0;
    bit                            quiet = 1'b0;     // no idling on either side
    bit                            held = 1'b0;
    int                            hold_left = 0;
    int                            stall_left = 0;
    logic [ptm_pkg::VA_W-1:0]      mapped_va [$];    // pages already requested, for reuse

    always #10 clk = ~clk;

    page_table_mapper u_top (.*);

    ptm_checker u_check (.*);

    // Watchdog: a hung handshake ends the run as a failure.
    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // Result side. One assignment of out_stall per falling edge: the long
    // hold first (it lets the block fill and push back on requests), then
    // random stall bursts, none once the run goes quiet.
    always @(negedge clk)
    begin
        if (!held && requests_sent >= HOLD_AFTER)
        begin
            held = 1'b1;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0)
        begin
            out_stall = 1'b1;
            hold_left--;
        end
        else if (quiet)
            out_stall = 1'b0;
        else if (stall_left > 0)
        begin
            out_stall = 1'b1;
            stall_left--;
        end
        else if ($urandom_range(0, 5) == 0)
        begin
            stall_left = $urandom_range(1, 13) - 1;
            out_stall = 1'b1;
        end
        else
            out_stall = 1'b0;
    end

    task automatic write_reg(input logic [ptm_pkg::CFG_IDX_W-1:0] idx,
                             input logic [ptm_pkg::PAGE_W-1:0] val);
        @(negedge clk);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = val;
        do
            @(posedge clk);
        while (!cfg_ready);
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    // Offers one request, sometimes after an idle burst, and holds it until taken.
    task automatic send_request(input logic [ptm_pkg::VA_W-1:0] va,
                                input logic [ptm_pkg::PAGE_W-1:0] pa,
                                input logic [ptm_pkg::ATTR_W-1:0] attr, input logic ro,
                                input logic ex);
        int gap;
        @(negedge clk);
        if (!quiet && $urandom_range(0, 4) == 0)
        begin
            gap = $urandom_range(1, 13);
            in_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid   = 1'b1;
        va_page    = va;
        pa_page    = pa;
        attr_index = attr;
        read_only  = ro;
        executable = ex;
        do
            @(posedge clk);
        while (in_stall);
        requests_sent++;
        mapped_va.push_back(va);
    endtask

    // Mostly pages inside tables already built or under L1 entries already
    // taken, so the maps get hit; the rest lands anywhere and drains the
    // pools until they run dry.
    task automatic random_request();
        logic [ptm_pkg::VA_W-1:0] seen;
        logic [ptm_pkg::VA_W-1:0] va;
        int                       pick;
        pick = $urandom_range(0, 9);
        seen = mapped_va[$urandom_range(0, mapped_va.size() - 1)];
        if (pick < 5)
            va = {seen[26:9], 9'($urandom)};
        else if (pick < 8)
            va = {seen[26:18], 18'($urandom)};
        else
            va = ptm_pkg::VA_W'($urandom);
        send_request(va, {4'($urandom), 32'($urandom)}, ptm_pkg::ATTR_W'($urandom),
                     1'($urandom), 1'($urandom));
    endtask

    // Idle point: every expected result in, then an idle wait for the pipeline.
    task automatic drain();
        @(negedge clk);
        in_valid = 1'b0;
        while (writes_pending != 0)
            @(negedge clk);
        repeat (10) @(negedge clk);
    endtask

    initial
    begin
        int k;
        repeat (4) @(negedge clk);
        rst_n = 1'b1;

        // Bases at the top of the page range so L2 table addresses wrap.
        // Writes go in during the clearing sweep; requests wait on in_stall.
        write_reg(ptm_pkg::REG_L2_POOL_BASE, '1);
        write_reg(ptm_pkg::REG_L3_POOL_BASE, 36'hFFFFFFFC0);

        // Directed: first page takes L2 and L3 tables, remap, last entry of the
        // same table, new L3 under an existing L2, top of the VA range, new L2.
        send_request(27'h0000000, '0, 3'd0, 1'b0, 1'b0);
        send_request(27'h0000000, '1, 3'd7, 1'b1, 1'b1);
        send_request(27'h00001FF, 36'h123456789, 3'd5, 1'b0, 1'b1);
        send_request({9'h000, 9'h1FF, 9'h000}, 36'hFEDCBA987, 3'd2, 1'b1, 1'b0);
        send_request(27'h7FFFFFF, '1, 3'd7, 1'b1, 1'b0);
        send_request(27'h7FFFE00, '0, 3'd0, 1'b0, 1'b1);
        send_request({9'h1FF, 9'h000, 9'h001}, 36'h800000001, 3'd3, 1'b0, 1'b0);
        send_request(27'h0040000, 36'h0000FFFFF, 3'd4, 1'b1, 1'b1);
        // every attribute index, with both flags in all combinations
        for (k = 0; k < 8; k++)
            send_request({9'h1FF, 9'h1FF, 9'(k * 73)}, {4'($urandom), 32'($urandom)},
                         ptm_pkg::ATTR_W'(k), k[0], k[1]);
        drain();

        write_reg(ptm_pkg::REG_L2_POOL_BASE, '0);
        write_reg(ptm_pkg::REG_L3_POOL_BASE, '0);
        repeat (60) random_request();
        drain();

        write_reg(ptm_pkg::REG_L2_POOL_BASE, {4'($urandom), 32'($urandom)});
        write_reg(ptm_pkg::REG_L3_POOL_BASE, {4'($urandom), 32'($urandom)});
        repeat (60) random_request();
        drain();

        write_reg(ptm_pkg::REG_L2_POOL_BASE, 36'h800000000);
        write_reg(ptm_pkg::REG_L3_POOL_BASE, '1);
        repeat (50) random_request();
        // closing stretch runs back to back on both sides
        quiet = 1'b1;
        repeat (40) random_request();
        drain();

        if (mismatches == 0 && writes_pending == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
